// ----- hdl/cdq_pkg.sv -----
package cdq_pkg;

   // Default ring size and field widths
   localparam int MAX_DEPTH_DEFAULT = 16;
   localparam int DATA_W            = 32;
   localparam int CMD_W             = 3;
   localparam int CAP_W             = 5;
   localparam int COUNT_W           = 5;

   // Capacity after reset, before clamping to the ring size
   localparam int CAP_RESET = 16;

   // Command codes; anything else behaves as a peek
   localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INS_REAR  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DEL_REAR  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_PEEK      = 3'd4;

   // Front and rear value reported while the deque is empty
   localparam logic signed [DATA_W-1:0] EMPTY_VALUE = '1;

endpackage

// ----- hdl/circular_deque_core.sv -----
// Double-ended queue held in a ring memory of MAX_DEPTH entries, of which
// csr_write_data selects how many are in use (0 counts as 1, values above
// MAX_DEPTH count as MAX_DEPTH); a capacity write also empties the queue and
// must only be issued while no beat is in flight. Each request beat inserts
// at the front or rear, deletes from the front or rear, or peeks, and yields
// exactly one response beat with the success flag, the front and rear values
// after the operation (-1 when empty), the empty and full flags and the count.
// The block sustains one beat per cycle while the response channel is not
// stalled: the pointer update and the memory write happen at acceptance, the
// new front and rear entries are read from the two read ports of the ring
// memory in the same cycle (a same-cycle write is forwarded), and the read
// stage then loads the response register, from which the response is sent.
// Back-pressure on the response channel stalls the read stage and then the
// request channel. The memory needs no clearing after reset.
module circular_deque_core #(
   parameter int MAX_DEPTH = cdq_pkg::MAX_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // Configuration
   input  logic                             csr_write_enable,
   input  logic [cdq_pkg::CAP_W-1:0]        csr_write_data,
   // Request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [cdq_pkg::CMD_W-1:0]        req_command,
   input  logic signed [cdq_pkg::DATA_W-1:0] req_data_value,
   // Response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_success,
   output logic signed [cdq_pkg::DATA_W-1:0] rsp_front_value,
   output logic signed [cdq_pkg::DATA_W-1:0] rsp_rear_value,
   output logic                             rsp_is_empty,
   output logic                             rsp_is_full,
   output logic [cdq_pkg::COUNT_W-1:0]      rsp_entry_count
);

   localparam int IdxW     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int CntW     = $clog2(MAX_DEPTH + 1);
   localparam int CapReset = (cdq_pkg::CAP_RESET > MAX_DEPTH) ? MAX_DEPTH : cdq_pkg::CAP_RESET;

   localparam logic [CntW-1:0] CapResetVal = CntW'(CapReset);
   localparam logic [IdxW-1:0] RearReset   = IdxW'(CapReset - 1);

   // Ring state
   logic [CntW-1:0] cap_ff;
   logic [IdxW-1:0] front_ff, front_in;
   logic [IdxW-1:0] rear_ff, rear_in;
   logic [CntW-1:0] count_ff, count_in;

   // Read stage
   logic                      s1_valid_ff, s1_valid_in;
   logic                      s1_success_ff;
   logic                      s1_empty_ff;
   logic                      s1_full_ff;
   logic [CntW-1:0]           s1_count_ff;
   logic                      s1_fwd_front_ff;
   logic                      s1_fwd_rear_ff;
   logic [cdq_pkg::DATA_W-1:0] s1_fwd_data_ff;

   // Response register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_success_ff;
   logic signed [cdq_pkg::DATA_W-1:0] rsp_front_ff;
   logic signed [cdq_pkg::DATA_W-1:0] rsp_rear_ff;
   logic                             rsp_is_empty_ff;
   logic                             rsp_is_full_ff;
   logic [cdq_pkg::COUNT_W-1:0]      rsp_count_ff;

   // Memory interface
   logic                      mem_wr_en;
   logic [IdxW-1:0]           mem_wr_addr;
   logic [cdq_pkg::DATA_W-1:0] mem_rd_a;
   logic [cdq_pkg::DATA_W-1:0] mem_rd_b;

   logic accept;
   logic s1_move;
   logic op_ok;
   logic [CntW-1:0] csr_cap;

   // Step an index forward or backward around the ring in use
   function automatic logic [IdxW-1:0] ring_next(input logic [IdxW-1:0] idx,
                                                 input logic [CntW-1:0] cap);
      logic [CntW:0] inc;
      inc = (CntW+1)'(idx) + 1'b1;
      ring_next = (inc >= (CntW+1)'(cap)) ? '0 : IdxW'(inc);
   endfunction

   function automatic logic [IdxW-1:0] ring_prev(input logic [IdxW-1:0] idx,
                                                 input logic [CntW-1:0] cap);
      ring_prev = (idx == '0) ? IdxW'(cap - 1'b1) : idx - 1'b1;
   endfunction

   // Handshakes: the read stage drains into the response register
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;

   // Clamp a written capacity into 1..MAX_DEPTH
   always_comb begin
      if (csr_write_data == '0) begin
         csr_cap = CntW'(1);
      end else if (32'(csr_write_data) > 32'(MAX_DEPTH)) begin
         csr_cap = CntW'(MAX_DEPTH);
      end else begin
         csr_cap = CntW'(csr_write_data);
      end
   end

   // Decode the command and work out the new pointers and count
   always_comb begin
      front_in    = front_ff;
      rear_in     = rear_ff;
      count_in    = count_ff;
      op_ok       = 1'b1;
      mem_wr_en   = 1'b0;
      mem_wr_addr = front_ff;
      unique case (req_command)
         cdq_pkg::CMD_INS_FRONT: begin
            if (count_ff >= cap_ff) begin
               op_ok = 1'b0;
            end else begin
               front_in    = ring_prev(front_ff, cap_ff);
               count_in    = count_ff + 1'b1;
               mem_wr_en   = accept;
               mem_wr_addr = front_in;
            end
         end
         cdq_pkg::CMD_INS_REAR: begin
            if (count_ff >= cap_ff) begin
               op_ok = 1'b0;
            end else begin
               rear_in     = ring_next(rear_ff, cap_ff);
               count_in    = count_ff + 1'b1;
               mem_wr_en   = accept;
               mem_wr_addr = rear_in;
            end
         end
         cdq_pkg::CMD_DEL_FRONT: begin
            if (count_ff == '0) begin
               op_ok = 1'b0;
            end else begin
               front_in = ring_next(front_ff, cap_ff);
               count_in = count_ff - 1'b1;
            end
         end
         cdq_pkg::CMD_DEL_REAR: begin
            if (count_ff == '0) begin
               op_ok = 1'b0;
            end else begin
               rear_in  = ring_prev(rear_ff, cap_ff);
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            // Peek and unused codes leave everything as it is
         end
      endcase
   end

   // Advance the ring state; a capacity write empties the deque
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CapResetVal;
         front_ff <= '0;
         rear_ff  <= RearReset;
         count_ff <= '0;
      end else if (csr_write_enable) begin
         cap_ff   <= csr_cap;
         front_ff <= '0;
         rear_ff  <= IdxW'(csr_cap - 1'b1);
         count_ff <= '0;
      end else if (accept) begin
         front_ff <= front_in;
         rear_ff  <= rear_in;
         count_ff <= count_in;
      end
   end

   // Ring memory: write the inserted value, read the new front and rear
   cdq_ram #(
      .WIDTH (cdq_pkg::DATA_W),
      .DEPTH (MAX_DEPTH)
   ) u_ring (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (mem_wr_addr),
      .wr_data   (req_data_value),
      .rd_en     (accept),
      .rd_addr_a (front_in),
      .rd_addr_b (rear_in),
      .rd_data_a (mem_rd_a),
      .rd_data_b (mem_rd_b)
   );

   // Read stage control
   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Capture flags and forward a value written in the same cycle it is read
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_success_ff   <= op_ok;
         s1_empty_ff     <= (count_in == '0);
         s1_full_ff      <= (count_in == cap_ff);
         s1_count_ff     <= count_in;
         s1_fwd_front_ff <= mem_wr_en && (mem_wr_addr == front_in);
         s1_fwd_rear_ff  <= mem_wr_en && (mem_wr_addr == rear_in);
         s1_fwd_data_ff  <= req_data_value;
      end
   end

   // Response register control
   always_comb begin
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the response beat; report -1 for both ends when empty
   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_success_ff  <= s1_success_ff;
         rsp_is_empty_ff <= s1_empty_ff;
         rsp_is_full_ff  <= s1_full_ff;
         rsp_count_ff    <= cdq_pkg::COUNT_W'(32'(s1_count_ff));
         if (s1_empty_ff) begin
            rsp_front_ff <= cdq_pkg::EMPTY_VALUE;
            rsp_rear_ff  <= cdq_pkg::EMPTY_VALUE;
         end else begin
            rsp_front_ff <= s1_fwd_front_ff ? s1_fwd_data_ff : mem_rd_a;
            rsp_rear_ff  <= s1_fwd_rear_ff ? s1_fwd_data_ff : mem_rd_b;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_success     = rsp_success_ff;
   assign rsp_front_value = rsp_front_ff;
   assign rsp_rear_value  = rsp_rear_ff;
   assign rsp_is_empty    = rsp_is_empty_ff;
   assign rsp_is_full     = rsp_is_full_ff;
   assign rsp_entry_count = rsp_count_ff;

`ifndef SYNTHESIS
   // The count never exceeds the capacity in use
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cap_ff)
      else $error("entry count above capacity");

   // An accepted beat always reaches the read stage
   a_accept_loads_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted beat lost before read stage");

   // A delete on an empty deque leaves it empty
   a_empty_delete: assert property (@(posedge clock) disable iff (reset)
      (accept && !csr_write_enable && count_ff == '0 &&
       (req_command == cdq_pkg::CMD_DEL_FRONT || req_command == cdq_pkg::CMD_DEL_REAR))
      |=> count_ff == '0)
      else $error("delete on empty deque changed the count");

   // An empty response reports -1 at both ends
   a_empty_values: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_is_empty_ff) |->
      (rsp_front_ff == cdq_pkg::EMPTY_VALUE && rsp_rear_ff == cdq_pkg::EMPTY_VALUE))
      else $error("empty response with stale values");
`endif

endmodule

// ----- hdl/cdq_ram.sv -----
module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]                         rd_data_a,
   output logic [WIDTH-1:0]                         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write one entry; read two entries, returning old data on a collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule
